[hw/rtl/spectrum_bar_history_slew_unit_assert.svh]
// Assertion macros for the block's port-level checker file.
`ifndef SPECTRUM_BAR_HISTORY_SLEW_UNIT_ASSERT_SVH
`define SPECTRUM_BAR_HISTORY_SLEW_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SBH_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sbh: implication check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define SBH_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sbh: next-cycle check failed");

`endif

[hw/rtl/sbh_pkg.sv]
// Package: sizes, types, codes and the band edge table of the spectrum bar history unit.
package sbh_pkg;

  localparam int unsigned BANDS     = 16;
  localparam int unsigned ROWS      = 16;
  localparam int unsigned BAND_W    = $clog2(BANDS);
  localparam int unsigned ROW_W     = $clog2(ROWS);
  localparam int unsigned ROW_CMP_W = ((ROW_W > 4) ? ROW_W : 4) + 1;
  localparam int unsigned DEPTH     = ROWS * BANDS;
  localparam int unsigned ADDR_W    = ROW_W + BAND_W;

  localparam int unsigned HEIGHT_W  = 16;
  localparam int unsigned PEAK_W    = 15;
  localparam int unsigned BIN_W     = 8;
  localparam int unsigned LOG_V_W   = 8;
  localparam int unsigned FRAC_BITS = 11;
  localparam int unsigned PROD_W    = 30;

  localparam int unsigned ROUND_BIAS  = 8192;
  localparam int unsigned ROUND_SHIFT = 14;

  localparam logic [BIN_W-1:0]    BIN_STOP   = 8'd255;
  localparam logic [HEIGHT_W-1:0] GAIN_RESET = 16'd16384;
  localparam logic [HEIGHT_W-1:0] SLEW_RESET = 16'd819;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic {
    REG_GAIN = 1'b0,
    REG_SLEW = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOG,
    ST_COPY,
    ST_TREAD,
    ST_TCALC,
    ST_TOUT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    LG_IDLE,
    LG_SQ,
    LG_GAIN,
    LG_RND
  } log_state_e;

  typedef struct packed {
    logic               op;
    logic signed [15:0] sample;
    logic               frame_end;
    logic [3:0]         row;
  } in_t;

  typedef struct packed {
    logic [3:0]  column;
    logic [15:0] shown_height;
    logic        last_bar;
  } out_t;

  typedef struct packed {
    logic               start;
    logic [LOG_V_W-1:0] v;
  } log_req_t;

  typedef struct packed {
    logic                done;
    logic [HEIGHT_W-1:0] height;
  } log_rsp_t;

  function automatic logic [BIN_W-1:0] band_edge(input logic [BAND_W:0] idx);
    logic [BIN_W-1:0] e;
    unique case (idx)
      5'd0:    e = 8'd0;
      5'd1:    e = 8'd1;
      5'd2:    e = 8'd2;
      5'd3:    e = 8'd3;
      5'd4:    e = 8'd5;
      5'd5:    e = 8'd7;
      5'd6:    e = 8'd10;
      5'd7:    e = 8'd14;
      5'd8:    e = 8'd20;
      5'd9:    e = 8'd28;
      5'd10:   e = 8'd40;
      5'd11:   e = 8'd54;
      5'd12:   e = 8'd74;
      5'd13:   e = 8'd101;
      5'd14:   e = 8'd137;
      5'd15:   e = 8'd187;
      default: e = 8'd255;
    endcase
    return e;
  endfunction

endpackage

[hw/rtl/spectrum_bar_history_slew_unit.sv]
// Top level: band peak tracking, history rows, slew sequencer and APB registers.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+---------------------------------
//   in       | in_valid_i / in_ready_o | in_data_i  (op, sample, frame_end, row)
//   out      | out_valid_o/out_ready_i | out_data_o (column, shown_height, last_bar)
//   cfg      | psel/penable/pready     | paddr, pwdata, prdata
//
// Sample: taken in ST_IDLE; one that closes a band or ends a frame inside a band runs the log unit
// (11 squarings plus gain and rounding in the shared multiplier; no squarings if peak >> 7 is zero).
// Frame end then makes one target RAM write per band (ST_COPY).
// Row tick: accepted in ST_IDLE, then ST_TREAD, ST_TCALC and ST_TOUT per bar; an output stall holds ST_TOUT.
// After reset a clearing pass writes zero to all DEPTH (256) entries of both RAMs.
// Input is taken only while idle; a stalled output holds the sequencer.
module spectrum_bar_history_slew_unit
  import sbh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ctrl_state_e state_q, state_d;

  logic [HEIGHT_W-1:0] gain_q;
  logic [HEIGHT_W-1:0] slew_q;
  logic [BIN_W-1:0]    bin_q, bin_d;
  logic [PEAK_W-1:0]   peak_q, peak_d;
  logic [BAND_W-1:0]   band_q, band_d;
  logic                fend_q, fend_d;
  logic                close_q, close_d;
  logic [BAND_W:0]     zero_from_q, zero_from_d;
  logic [ROW_W-1:0]    head_q, head_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [ROW_W-1:0]    phys_q, phys_d;
  logic [BAND_W-1:0]   x_q, x_d;
  logic [ADDR_W-1:0]   clr_q, clr_d;
  logic                out_valid_q, out_valid_d;
  out_t                out_q, out_d;
  logic [HEIGHT_W-1:0] new_row_q [BANDS];

  logic in_acc;
  logic out_acc;
  logic cfg_wr;

  logic [BIN_W-1:0]     c_next;
  logic                 band_start;
  logic                 band_close;
  logic [PEAK_W-1:0]    peak_base;
  logic [PEAK_W-1:0]    peak_new;
  logic                 need_log;
  logic [ROW_CMP_W-1:0] row_ext;
  logic                 row_ok;
  logic [ROW_W-1:0]     row_idx;
  logic [ROW_W:0]       phys_sum;
  logic [ROW_W-1:0]     phys_new;
  logic [ROW_W-1:0]     head_dec;
  logic                 x_last;

  logic [HEIGHT_W-1:0] cur;
  logic [HEIGHT_W-1:0] tgt;
  logic [HEIGHT_W-1:0] diff;
  logic [HEIGHT_W-1:0] slewed;
  logic [HEIGHT_W-1:0] copy_data;

  logic                tgt_we, shown_we;
  logic [ADDR_W-1:0]   tgt_waddr, shown_waddr;
  logic [HEIGHT_W-1:0] tgt_wdata, shown_wdata;
  logic [HEIGHT_W-1:0] tgt_rdata, shown_rdata;

  log_req_t log_req;
  log_rsp_t log_rsp;

  assign in_acc  = in_valid_i & in_ready_o;
  assign out_acc = out_valid_q & out_ready_i;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign pready  = 1'b1;

  // sample path
  assign c_next     = bin_q + 8'd1;
  assign band_start = (bin_q == band_edge({1'b0, band_q}));
  assign band_close = (c_next == band_edge({1'b0, band_q} + 5'd1));
  assign peak_base  = band_start ? '0 : peak_q;
  assign peak_new   = (!in_data_i.sample[15] && (in_data_i.sample[14:0] > peak_base))
                      ? in_data_i.sample[14:0] : peak_base;
  assign need_log   = (bin_q != BIN_STOP) && (band_close || in_data_i.frame_end);

  // row mapping
  assign row_ext  = ROW_CMP_W'(in_data_i.row);
  assign row_ok   = row_ext < ROW_CMP_W'(ROWS);
  assign row_idx  = row_ext[ROW_W-1:0];
  assign phys_sum = {1'b0, head_q} + {1'b0, row_idx};
  assign phys_new = (phys_sum >= (ROW_W+1)'(ROWS))
                    ? ROW_W'(phys_sum - (ROW_W+1)'(ROWS)) : phys_sum[ROW_W-1:0];
  assign head_dec = (head_q == '0) ? ROW_W'(ROWS - 1) : head_q - 1'b1;
  assign x_last   = (x_q == BAND_W'(BANDS - 1));

  // slew
  assign cur    = shown_rdata;
  assign tgt    = tgt_rdata;
  assign diff   = (cur > tgt) ? cur - tgt : tgt - cur;
  assign slewed = (diff > slew_q) ? ((cur < tgt) ? cur + slew_q : cur - slew_q) : cur;

  assign copy_data = ({1'b0, x_q} < zero_from_q) ? new_row_q[x_q] : '0;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.op == OP_TICK) begin
            if (row_ok) begin
              state_d = ST_TREAD;
            end
          end else if (need_log) begin
            state_d = ST_LOG;
          end else if (in_data_i.frame_end) begin
            state_d = ST_COPY;
          end
        end
      end
      ST_LOG: begin
        if (log_rsp.done) begin
          state_d = fend_q ? ST_COPY : ST_IDLE;
        end
      end
      ST_COPY: begin
        if (x_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_TREAD: state_d = ST_TCALC;
      ST_TCALC: state_d = ST_TOUT;
      ST_TOUT: begin
        if (out_ready_i) begin
          state_d = x_last ? ST_IDLE : ST_TREAD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o    = 1'b0;
    log_req.start = 1'b0;
    log_req.v     = peak_new[PEAK_W-1:PEAK_W-LOG_V_W];
    tgt_we        = 1'b0;
    tgt_waddr     = {head_q, x_q};
    tgt_wdata     = copy_data;
    shown_we      = 1'b0;
    shown_waddr   = {row_q, x_q};
    shown_wdata   = slewed;
    unique case (state_q)
      ST_CLEAR: begin
        tgt_we      = 1'b1;
        tgt_waddr   = clr_q;
        tgt_wdata   = '0;
        shown_we    = 1'b1;
        shown_waddr = clr_q;
        shown_wdata = '0;
      end
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        log_req.start = in_valid_i && (in_data_i.op == OP_SAMPLE) && need_log;
      end
      ST_COPY:  tgt_we   = 1'b1;
      ST_TCALC: shown_we = 1'b1;
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    bin_d       = bin_q;
    peak_d      = peak_q;
    band_d      = band_q;
    fend_d      = fend_q;
    close_d     = close_q;
    zero_from_d = zero_from_q;
    head_d      = head_q;
    row_d       = row_q;
    phys_d      = phys_q;
    x_d         = x_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    case (state_q)
      ST_CLEAR: clr_d = clr_q + 1'b1;
      ST_IDLE: begin
        if (in_acc) begin
          x_d = '0;
          if (in_data_i.op == OP_TICK) begin
            row_d  = row_idx;
            phys_d = phys_new;
          end else begin
            fend_d  = in_data_i.frame_end;
            close_d = band_close;
            if (bin_q != BIN_STOP) begin
              bin_d       = c_next;
              peak_d      = peak_new;
              zero_from_d = {1'b0, band_q} + 5'd1;
              if (band_close && !need_log) begin
                band_d = band_q;
              end
            end else begin
              zero_from_d = 5'(BANDS);
            end
            if (in_data_i.frame_end) begin
              bin_d  = '0;
              peak_d = '0;
              if (!need_log) begin
                band_d = '0;
                head_d = head_dec;
              end
            end
          end
        end
      end
      ST_LOG: begin
        if (log_rsp.done) begin
          if (fend_q) begin
            band_d = '0;
            head_d = head_dec;
          end else if (close_q && (band_q != BAND_W'(BANDS - 1))) begin
            band_d = band_q + 1'b1;
          end
        end
      end
      ST_COPY: x_d = x_q + 1'b1;
      ST_TCALC: begin
        out_valid_d        = 1'b1;
        out_d.column       = x_q;
        out_d.shown_height = slewed;
        out_d.last_bar     = x_last;
      end
      ST_TOUT: begin
        if (out_acc) begin
          out_valid_d = 1'b0;
          x_d         = x_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      gain_q      <= GAIN_RESET;
      slew_q      <= SLEW_RESET;
      bin_q       <= '0;
      peak_q      <= '0;
      band_q      <= '0;
      fend_q      <= 1'b0;
      close_q     <= 1'b0;
      zero_from_q <= '0;
      head_q      <= '0;
      row_q       <= '0;
      phys_q      <= '0;
      x_q         <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bin_q       <= bin_d;
      peak_q      <= peak_d;
      band_q      <= band_d;
      fend_q      <= fend_d;
      close_q     <= close_d;
      zero_from_q <= zero_from_d;
      head_q      <= head_d;
      row_q       <= row_d;
      phys_q      <= phys_d;
      x_q         <= x_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr) begin
        unique case (reg_e'(paddr[2]))
          REG_GAIN: gain_q <= pwdata[HEIGHT_W-1:0];
          REG_SLEW: slew_q <= pwdata[HEIGHT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if ((state_q == ST_LOG) && log_rsp.done) begin
      new_row_q[band_q] <= log_rsp.height;
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[2]))
      REG_GAIN: prdata = {16'd0, gain_q};
      REG_SLEW: prdata = {16'd0, slew_q};
      default:  prdata = '0;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  sbh_log_unit u_log (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .gain_i (gain_q),
    .req_i  (log_req),
    .rsp_o  (log_rsp)
  );

  sbh_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (DEPTH)
  ) u_target_ram (
    .clk_i   (clk_i),
    .we_i    (tgt_we),
    .waddr_i (tgt_waddr),
    .wdata_i (tgt_wdata),
    .raddr_i ({phys_q, x_q}),
    .rdata_o (tgt_rdata)
  );

  sbh_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (DEPTH)
  ) u_shown_ram (
    .clk_i   (clk_i),
    .we_i    (shown_we),
    .waddr_i (shown_waddr),
    .wdata_i (shown_wdata),
    .raddr_i ({row_q, x_q}),
    .rdata_o (shown_rdata)
  );

endmodule

[hw/rtl/sbh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sbh_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/sbh_log_unit.sv]
// Iterative log2 and gain unit built around one shared 16x16 multiplier.
module sbh_log_unit
  import sbh_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [HEIGHT_W-1:0] gain_i,
  input  log_req_t            req_i,
  output log_rsp_t            rsp_o
);

  log_state_e state_q, state_d;

  logic [15:0]          m_q;
  logic [2:0]           e_q;
  logic [FRAC_BITS-1:0] frac_q;
  logic [3:0]           k_q;
  logic [PROD_W-1:0]    prod_q;

  logic [2:0]  e_lead;
  logic [15:0] m_init;
  logic [15:0] mult_a;
  logic [15:0] mult_b;
  logic [31:0] mult_p;
  logic [16:0] sq;
  logic [30:0] rnd_sum;
  logic [16:0] h_full;

  always_comb begin
    e_lead = 3'd0;
    for (int i = 1; i < LOG_V_W; i++) begin
      if (req_i.v[i]) begin
        e_lead = 3'(i);
      end
    end
    m_init = {8'd0, req_i.v} << (4'd15 - {1'b0, e_lead});
  end

  assign mult_p  = {16'd0, mult_a} * {16'd0, mult_b};
  assign sq      = mult_p[31:15];
  assign rnd_sum = {1'b0, prod_q} + 31'(ROUND_BIAS);
  assign h_full  = 17'(rnd_sum >> ROUND_SHIFT);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      LG_IDLE: begin
        if (req_i.start) begin
          state_d = (req_i.v == '0) ? LG_RND : LG_SQ;
        end
      end
      LG_SQ: begin
        if (k_q == 4'(FRAC_BITS - 1)) begin
          state_d = LG_GAIN;
        end
      end
      LG_GAIN: state_d = LG_RND;
      LG_RND:  state_d = LG_IDLE;
      default: state_d = LG_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    mult_a       = m_q;
    mult_b       = m_q;
    rsp_o.done   = 1'b0;
    rsp_o.height = h_full[16] ? '1 : h_full[15:0];
    unique case (state_q)
      LG_GAIN: begin
        mult_a = {2'b00, e_q, frac_q};
        mult_b = gain_i;
      end
      LG_RND:  rsp_o.done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LG_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      LG_IDLE: begin
        if (req_i.start) begin
          m_q    <= m_init;
          e_q    <= e_lead;
          frac_q <= '0;
          k_q    <= '0;
          prod_q <= '0;
        end
      end
      LG_SQ: begin
        m_q    <= sq[16] ? sq[16:1] : sq[15:0];
        frac_q <= {frac_q[FRAC_BITS-2:0], sq[16]};
        k_q    <= k_q + 4'd1;
      end
      LG_GAIN: prod_q <= mult_p[PROD_W-1:0];
      default: ;
    endcase
  end

endmodule

[hw/rtl/sbh_checker.sv]
// Port-level checker for the spectrum bar history unit, bound to the top level.
`include "spectrum_bar_history_slew_unit_assert.svh"

module sbh_checker
  import sbh_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  `SBH_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i,
                  out_valid_o && $stable(out_data_o))

  `SBH_ASSERT_IMP(a_ready_no_pending, in_ready_o, !out_valid_o)

  `SBH_ASSERT_NXT(a_row_continues, out_valid_o && out_ready_i && !out_data_o.last_bar,
                  !in_ready_o)

  `SBH_ASSERT_NXT(a_no_same_cycle_result, in_valid_i && in_ready_o, !out_valid_o)

  `SBH_ASSERT_IMP(a_last_bar_column, out_valid_o,
                  out_data_o.last_bar == (out_data_o.column == 4'd15))

endmodule

bind spectrum_bar_history_slew_unit sbh_checker u_sbh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

[tb/sbh_bar_checker.sv]
// Checker: watches the channels, predicts the bars of every transaction and compares them.
module sbh_bar_checker
  import sbh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_t        out_data_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o
);

  localparam logic [7:0] EDGE [0:16] = '{
    8'd0, 8'd1, 8'd2, 8'd3, 8'd5, 8'd7, 8'd10, 8'd14, 8'd20, 8'd28,
    8'd40, 8'd54, 8'd74, 8'd101, 8'd137, 8'd187, 8'd255
  };

  logic [15:0] gain_q;
  logic [15:0] slew_q;
  logic [14:0] peak_q;
  logic [7:0]  bin_q;
  logic [15:0] new_row_q [BANDS];
  logic [15:0] target_q  [ROWS][BANDS];
  logic [15:0] shown_q   [ROWS][BANDS];

  out_t        expected_bars [$];
  int unsigned mismatch_cnt;

  // log2(v)/8 in Q2.14, fraction found by repeated squaring
  function automatic logic [15:0] log2_fix(input logic [7:0] v);
    int unsigned e;
    logic [63:0] m;
    logic [10:0] frac;
    e = 0;
    for (int i = 1; i < 8; i++) if (v[i]) e = i;
    m = 64'(v) << (15 - e);
    frac = '0;
    for (int k = 0; k < 11; k++) begin
      m = (m * m) >> 15;
      frac = {frac[9:0], 1'b0};
      if (m >= 64'd65536) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return 16'(e * 2048 + frac);
  endfunction

  function automatic logic [15:0] peak_to_height(input logic [14:0] peak);
    logic [7:0]  v;
    logic [63:0] h;
    v = peak[14:7];
    if (v == 8'd0) return 16'd0;
    h = (64'(log2_fix(v)) * 64'(gain_q) + 64'd8192) >> 14;
    if (h > 64'd65535) return 16'hffff;
    return h[15:0];
  endfunction

  function automatic int unsigned band_of(input int unsigned c);
    int unsigned b;
    b = 0;
    while (b + 1 < BANDS && EDGE[b+1] <= c) b++;
    return b;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned exp_v,
                                 input int unsigned got_v);
    $display("MISMATCH %s: expected %0d, got %0d", what, exp_v, got_v);
    mismatch_cnt++;
  endtask

  task automatic predict_item(input in_t t);
    int unsigned c;
    int unsigned last;
    int unsigned bd;
    int unsigned r;
    logic [15:0] cur;
    logic [15:0] tgt;
    logic [15:0] diff;
    out_t        bar;
    if (t.op == OP_SAMPLE) begin
      c = bin_q;
      if (c < 255) begin
        bd = band_of(c);
        if (c == EDGE[bd]) peak_q = '0;
        if (!t.sample[15] && t.sample[14:0] > peak_q) peak_q = t.sample[14:0];
        if (c + 1 == EDGE[bd+1]) new_row_q[bd] = peak_to_height(peak_q);
        bin_q = 8'(c + 1);
        last = c;
      end else begin
        last = 254;
      end
      if (t.frame_end) begin
        for (int b = 0; b < BANDS; b++) begin
          if (int'(EDGE[b+1]) - 1 <= int'(last)) begin
            // band already closed this frame
          end else if (EDGE[b] <= last) begin
            new_row_q[b] = peak_to_height(peak_q);
          end else begin
            new_row_q[b] = '0;
          end
        end
        for (int rr = ROWS - 1; rr > 0; rr--)
          for (int b = 0; b < BANDS; b++) target_q[rr][b] = target_q[rr-1][b];
        for (int b = 0; b < BANDS; b++) target_q[0][b] = new_row_q[b];
        bin_q = '0;
        peak_q = '0;
      end
    end else begin
      r = t.row;
      if (r < ROWS) begin
        for (int x = 0; x < BANDS; x++) begin
          cur = shown_q[r][x];
          tgt = target_q[r][x];
          diff = (cur > tgt) ? cur - tgt : tgt - cur;
          if (diff > slew_q) cur = (cur < tgt) ? cur + slew_q : cur - slew_q;
          shown_q[r][x] = cur;
          bar.column = 4'(x);
          bar.shown_height = cur;
          bar.last_bar = (x == BANDS - 1);
          expected_bars.push_back(bar);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      gain_q = GAIN_RESET;
      slew_q = SLEW_RESET;
      peak_q = '0;
      bin_q = '0;
      for (int b = 0; b < BANDS; b++) new_row_q[b] = '0;
      for (int rr = 0; rr < ROWS; rr++)
        for (int b = 0; b < BANDS; b++) begin
          target_q[rr][b] = '0;
          shown_q[rr][b] = '0;
        end
      expected_bars.delete();
      mismatch_cnt = 0;
      mismatches_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_bars.size() == 0) begin
          report_mismatch("bar with none pending, column", 0, out_data_i.column);
        end else begin
          want = expected_bars.pop_front();
          if (out_data_i.column !== want.column)
            report_mismatch("column", want.column, out_data_i.column);
          if (out_data_i.shown_height !== want.shown_height)
            report_mismatch("shown_height", want.shown_height, out_data_i.shown_height);
          if (out_data_i.last_bar !== want.last_bar)
            report_mismatch("last_bar", want.last_bar, out_data_i.last_bar);
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (reg_e'(paddr_i[2]) == REG_GAIN) gain_q = pwdata_i[15:0];
        else slew_q = pwdata_i[15:0];
      end
      if (in_valid_i && in_ready_i) predict_item(in_data_i);
      mismatches_o <= mismatch_cnt;
      pending_o <= expected_bars.size();
    end
  end

endmodule

[tb/tb.sv]
// Testbench top: clock, reset, stimulus, register writes and the final verdict.
module tb;
  import sbh_pkg::*;

  localparam int unsigned SETTLE = 64;
  localparam int unsigned LIMIT  = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;

  spectrum_bar_history_slew_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  sbh_bar_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_item(input in_t t);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk_i); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_sample(input logic [15:0] s, input logic fend);
    in_t t;
    t = '0;
    t.op = OP_SAMPLE;
    t.sample = s;
    t.frame_end = fend;
    t.row = 4'($urandom);
    push_item(t);
  endtask

  task automatic send_tick(input logic [3:0] row);
    in_t t;
    t = '0;
    t.op = OP_TICK;
    t.row = row;
    t.sample = 16'($urandom);
    t.frame_end = 1'($urandom);
    push_item(t);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(3))
      0:       return 16'($urandom_range(255));
      1:       return 16'($urandom_range(32767));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [3:0] rand_row();
    if ($urandom_range(3) == 0) return 4'($urandom_range(15));
    return 4'($urandom_range(3));
  endfunction

  task automatic send_frame(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_sample(rand_sample(), i == len - 1);
  endtask

  // stop sending and wait until every expected bar has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic apb_write(input reg_e idx, input logic [15:0] val);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    int unsigned start;
    int unsigned len;
    in_t noise;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset gain and slew
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'd128, 1'b0);
    send_sample(16'h7f80, 1'b0);
    send_sample(16'hffff, 1'b0);
    send_sample(16'd1000, 1'b1);
    send_tick(4'd0);
    send_tick(4'd0);
    send_tick(4'd15);
    send_sample(16'd0, 1'b1);
    send_sample(16'd5000, 1'b0);
    send_sample(16'd20000, 1'b1);
    send_sample(16'd127, 1'b1);
    send_tick(4'd3);
    send_tick(4'd2);
    send_tick(4'd1);
    send_tick(4'd0);
    send_tick(4'd10);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 11;
          recv_idle_pct = 74;
        end
        1: begin
          sender_idle_pct = 74;
          recv_idle_pct = 11;
        end
        default: begin
          sender_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int sub = 0; sub < 2; sub++) begin
        case (phase * 2 + sub)
          0: begin
            apb_write(REG_GAIN, 16'hffff);
            apb_write(REG_SLEW, 16'd1);
          end
          1: begin
            apb_write(REG_GAIN, 16'd0);
            apb_write(REG_SLEW, 16'hffff);
          end
          2: begin
            apb_write(REG_GAIN, 16'($urandom));
            apb_write(REG_SLEW, 16'd0);
          end
          3: begin
            apb_write(REG_GAIN, GAIN_RESET);
            apb_write(REG_SLEW, 16'($urandom_range(1, 2000)));
          end
          4: begin
            apb_write(REG_GAIN, 16'($urandom));
            apb_write(REG_SLEW, 16'($urandom_range(0, 4000)));
          end
          default: begin
            apb_write(REG_GAIN, 16'hffff);
            apb_write(REG_SLEW, SLEW_RESET);
          end
        endcase
        start = items_sent;
        while (items_sent - start < 10) begin
          case ($urandom_range(9)) inside
            [0:5]: begin
              len = ($urandom_range(7) == 0) ? $urandom_range(11, 16) : $urandom_range(1, 10);
              send_frame(len);
              repeat ($urandom_range(1, 3)) send_tick(rand_row());
            end
            [6:7]: begin
              repeat ($urandom_range(1, 4)) send_tick(rand_row());
            end
            default: begin
              repeat ($urandom_range(1, 3)) begin
                noise = '0;
                noise.op = 1'($urandom);
                noise.sample = 16'($urandom);
                noise.frame_end = 1'($urandom);
                noise.row = 4'($urandom);
                push_item(noise);
              end
            end
          endcase
        end
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/sbh_pkg.sv
hw/rtl/sbh_ram.sv
hw/rtl/sbh_log_unit.sv
hw/rtl/spectrum_bar_history_slew_unit.sv
hw/rtl/sbh_checker.sv
tb/sbh_bar_checker.sv
tb/tb.sv
